@@ src/simp_pkg.sv @@
package simp_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int COUNT_WIDTH  = 16;
  localparam int NUM_W        = 16;
  localparam int STEP_W       = 32;
  localparam int OUT_W        = 64;

  localparam int SUM_S_RAW = SAMPLE_WIDTH + COUNT_WIDTH + 4;
  localparam int SUM_S_W   = (SUM_S_RAW > 60) ? 60 : SUM_S_RAW;
  localparam int SUM_T_W   = SAMPLE_WIDTH + 4;

  localparam int WS_W = 3;
  localparam int WT_W = 2;

  localparam int IN_DATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = 2 * OUT_W;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = STEP_W;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_H     = 1'b1;
  localparam logic [NUM_W-1:0]     NUM_POINTS_RST = NUM_W'(3);
  localparam logic [STEP_W-1:0]    STEP_H_RST     = STEP_W'(32'h0100_0000);

  localparam int N_W       = SUM_S_W + 4;
  localparam int MUL_LO_W  = N_W / 2;
  localparam int MUL_HI_W  = N_W - MUL_LO_W;
  localparam int PL_W      = MUL_LO_W + STEP_W;
  localparam int PH_W      = MUL_HI_W + STEP_W;
  localparam int PROD_W    = N_W + STEP_W;
  localparam int QUO_W     = PROD_W - 3;
  localparam int DIV_DIGIT = 8;
  localparam int DIV_STEPS = (QUO_W + DIV_DIGIT - 1) / DIV_DIGIT;
  localparam int DIV_W     = DIV_STEPS * DIV_DIGIT;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int ROUND_ADD = 12;

  typedef struct packed {
    logic                           err;
    logic                           first;
    logic                           last;
    logic [WS_W-1:0]                ws;
    logic [WT_W-1:0]                wt;
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
  } entry_t;

  typedef struct packed {
    logic                      err;
    logic signed [SUM_S_W-1:0] s_re;
    logic signed [SUM_S_W-1:0] s_im;
    logic signed [SUM_T_W-1:0] t_re;
    logic signed [SUM_T_W-1:0] t_im;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SUM,
    F_MAG,
    F_MUL,
    F_ADD,
    F_DIV,
    F_OUT
  } fin_state_e;

endpackage

@@ src/simp_front.sv @@
module simp_front (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [simp_pkg::SAMPLE_WIDTH-1:0] in_re_i,
  input  logic signed [simp_pkg::SAMPLE_WIDTH-1:0] in_im_i,
  input  logic [simp_pkg::NUM_W-1:0]               num_points_i,
  output logic                                     push_o,
  input  logic                                     push_ready_i,
  output simp_pkg::entry_t                         entry_o
);

  localparam int CW = simp_pkg::COUNT_WIDTH;

  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] n, i_eff, n_m1, n_m4, k;
  logic          err, last, accept;
  logic [simp_pkg::WS_W-1:0] ws;
  logic [simp_pkg::WT_W-1:0] wt;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign push_o     = accept;

  always_comb begin
    n     = CW'(num_points_i);
    err   = n < CW'(3);
    i_eff = (idx_q >= n) ? '0 : idx_q;
    n_m1  = n - CW'(1);
    n_m4  = n - CW'(4);
    last  = (i_eff == n_m1);
    k     = i_eff - n_m4;
    ws    = '0;
    wt    = '0;
    if (n[0]) begin
      if (i_eff == '0 || last) ws = simp_pkg::WS_W'(1);
      else ws = i_eff[0] ? simp_pkg::WS_W'(4) : simp_pkg::WS_W'(2);
    end else begin
      if (n > CW'(4) && i_eff <= n_m4) begin
        if (i_eff == '0 || i_eff == n_m4) ws = simp_pkg::WS_W'(1);
        else ws = i_eff[0] ? simp_pkg::WS_W'(4) : simp_pkg::WS_W'(2);
      end
      if (i_eff >= n_m4) begin
        wt = (k == '0 || k == CW'(3)) ? simp_pkg::WT_W'(1) : simp_pkg::WT_W'(3);
      end
    end

    entry_o.err   = err;
    entry_o.first = (i_eff == '0);
    entry_o.last  = last;
    entry_o.ws    = ws;
    entry_o.wt    = wt;
    entry_o.re    = in_re_i;
    entry_o.im    = in_im_i;

    idx_d = idx_q;
    if (accept) begin
      idx_d = (err || last) ? '0 : i_eff + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ src/simp_fifo.sv @@
module simp_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  simp_pkg::entry_t push_data_i,
  output logic             head_valid_o,
  input  logic             pop_i,
  output simp_pkg::entry_t head_o
);

  localparam int PW = simp_pkg::FIFO_PTR_W;

  simp_pkg::entry_t mem_q [simp_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != (PW+1)'(simp_pkg::FIFO_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + PW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + (PW+1)'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - (PW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule

@@ src/simp_accum.sv @@
module simp_accum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  simp_pkg::entry_t head_i,
  output logic             pop_o,
  input  logic             fin_ready_i,
  output logic             job_valid_o,
  output simp_pkg::job_t   job_o
);

  localparam int SW = simp_pkg::SAMPLE_WIDTH;
  localparam int SS = simp_pkg::SUM_S_W;
  localparam int ST = simp_pkg::SUM_T_W;

  logic signed [SS-1:0] s_re_q, s_re_d, s_im_q, s_im_d, s_re_n, s_im_n;
  logic signed [ST-1:0] t_re_q, t_re_d, t_im_q, t_im_d, t_re_n, t_im_n;
  logic                 closing;

  function automatic logic signed [SS-1:0] acc_s(input logic signed [SS-1:0] base,
                                                 input logic [simp_pkg::WS_W-1:0] w,
                                                 input logic signed [SW-1:0] x);
    logic signed [SS:0] xe, d, r;
    xe = (SS+1)'(x);
    case (w)
      simp_pkg::WS_W'(1): d = xe;
      simp_pkg::WS_W'(2): d = xe <<< 1;
      simp_pkg::WS_W'(4): d = xe <<< 2;
      default:            d = '0;
    endcase
    r = (SS+1)'(base) + d;
    if (r[SS] != r[SS-1]) return r[SS] ? {1'b1, {(SS-1){1'b0}}} : {1'b0, {(SS-1){1'b1}}};
    return r[SS-1:0];
  endfunction

  function automatic logic signed [ST-1:0] acc_t(input logic signed [ST-1:0] base,
                                                 input logic [simp_pkg::WT_W-1:0] w,
                                                 input logic signed [SW-1:0] x);
    logic signed [ST:0] xe, d, r;
    xe = (ST+1)'(x);
    case (w)
      simp_pkg::WT_W'(1): d = xe;
      simp_pkg::WT_W'(3): d = xe + (xe <<< 1);
      default:            d = '0;
    endcase
    r = (ST+1)'(base) + d;
    if (r[ST] != r[ST-1]) return r[ST] ? {1'b1, {(ST-1){1'b0}}} : {1'b0, {(ST-1){1'b1}}};
    return r[ST-1:0];
  endfunction

  always_comb begin
    closing = head_i.err || head_i.last;
    pop_o   = head_valid_i && (!closing || fin_ready_i);

    s_re_n = acc_s(head_i.first ? '0 : s_re_q, head_i.ws, head_i.re);
    s_im_n = acc_s(head_i.first ? '0 : s_im_q, head_i.ws, head_i.im);
    t_re_n = acc_t(head_i.first ? '0 : t_re_q, head_i.wt, head_i.re);
    t_im_n = acc_t(head_i.first ? '0 : t_im_q, head_i.wt, head_i.im);

    job_valid_o = pop_o && closing;
    job_o.err   = head_i.err;
    job_o.s_re  = s_re_n;
    job_o.s_im  = s_im_n;
    job_o.t_re  = t_re_n;
    job_o.t_im  = t_im_n;

    s_re_d = s_re_q;
    s_im_d = s_im_q;
    t_re_d = t_re_q;
    t_im_d = t_im_q;
    if (pop_o) begin
      if (closing) begin
        s_re_d = '0;
        s_im_d = '0;
        t_re_d = '0;
        t_im_d = '0;
      end else begin
        s_re_d = s_re_n;
        s_im_d = s_im_n;
        t_re_d = t_re_n;
        t_im_d = t_im_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_re_q <= '0;
      s_im_q <= '0;
      t_re_q <= '0;
      t_im_q <= '0;
    end else begin
      s_re_q <= s_re_d;
      s_im_q <= s_im_d;
      t_re_q <= t_re_d;
      t_im_q <= t_im_d;
    end
  end

endmodule

@@ src/simp_finish.sv @@
module simp_finish (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             job_valid_i,
  input  simp_pkg::job_t                   job_i,
  output logic                             ready_o,
  input  logic [simp_pkg::STEP_W-1:0]      step_h_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [simp_pkg::OUT_W-1:0]       out_re_o,
  output logic [simp_pkg::OUT_W-1:0]       out_im_o,
  output logic                             out_err_o
);

  localparam int SS  = simp_pkg::SUM_S_W;
  localparam int ST  = simp_pkg::SUM_T_W;
  localparam int NW  = simp_pkg::N_W;
  localparam int LO  = simp_pkg::MUL_LO_W;
  localparam int DW  = simp_pkg::DIV_W;
  localparam int DG  = simp_pkg::DIV_DIGIT;
  localparam int OW  = simp_pkg::OUT_W;
  localparam int PRW = simp_pkg::PROD_W;
  localparam int CNW = simp_pkg::DIV_CNT_W;

  simp_pkg::fin_state_e state_q, state_d;

  logic                        err_q;
  logic signed [SS-1:0]        s_re_q, s_im_q;
  logic signed [ST-1:0]        t_re_q, t_im_q;
  logic signed [NW-1:0]        n_re_q, n_im_q;
  logic [NW-1:0]               mag_re_q, mag_im_q;
  logic                        neg_re_q, neg_im_q;
  logic [simp_pkg::PL_W-1:0]   pl_re_q, pl_im_q;
  logic [simp_pkg::PH_W-1:0]   ph_re_q, ph_im_q;
  logic [DW-1:0]               div_re_q, div_im_q, quo_re_q, quo_im_q;
  logic [1:0]                  rem_re_q, rem_im_q;
  logic [CNW-1:0]              cnt_q;
  logic [PRW-1:0]              p_re, p_im;
  logic [DG+1:0]               dig_re, dig_im;
  logic                        out_valid_q;
  logic [OW-1:0]               out_re_q, out_im_q;
  logic                        out_err_q;
  logic                        out_free, write_out;

  function automatic logic [DG+1:0] div3_digit(input logic [1:0] r_in,
                                              input logic [DG-1:0] dg);
    logic [1:0]    r;
    logic [2:0]    t;
    logic [DG-1:0] q;
    r = r_in;
    q = '0;
    for (int j = DG - 1; j >= 0; j--) begin
      t = {r, dg[j]};
      if (t >= 3'd3) begin
        q[j] = 1'b1;
        t    = t - 3'd3;
      end
      r = t[1:0];
    end
    return {r, q};
  endfunction

  function automatic logic [OW-1:0] sat_out(input logic neg, input logic [DW-1:0] quo);
    logic [OW-1:0] lo;
    lo = quo[OW-1:0];
    if (|quo[DW-1:OW-1]) return neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    return neg ? (~lo + OW'(1)) : lo;
  endfunction

  assign ready_o     = (state_q == simp_pkg::F_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign write_out   = (state_q == simp_pkg::F_OUT) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign out_err_o   = out_err_q;

  assign p_re = (PRW'(ph_re_q) << LO) + PRW'(pl_re_q) + PRW'(simp_pkg::ROUND_ADD);
  assign p_im = (PRW'(ph_im_q) << LO) + PRW'(pl_im_q) + PRW'(simp_pkg::ROUND_ADD);
  assign dig_re = div3_digit(rem_re_q, div_re_q[DW-1 -: DG]);
  assign dig_im = div3_digit(rem_im_q, div_im_q[DW-1 -: DG]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      simp_pkg::F_IDLE: if (job_valid_i) state_d = job_i.err ? simp_pkg::F_OUT : simp_pkg::F_SUM;
      simp_pkg::F_SUM:  state_d = simp_pkg::F_MAG;
      simp_pkg::F_MAG:  state_d = simp_pkg::F_MUL;
      simp_pkg::F_MUL:  state_d = simp_pkg::F_ADD;
      simp_pkg::F_ADD:  state_d = simp_pkg::F_DIV;
      simp_pkg::F_DIV:  if (cnt_q == CNW'(simp_pkg::DIV_STEPS - 1)) state_d = simp_pkg::F_OUT;
      simp_pkg::F_OUT:  if (out_free) state_d = simp_pkg::F_IDLE;
      default:          state_d = simp_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= simp_pkg::F_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == simp_pkg::F_ADD) cnt_q <= '0;
      else if (state_q == simp_pkg::F_DIV) cnt_q <= cnt_q + CNW'(1);
      if (write_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      simp_pkg::F_IDLE: begin
        if (job_valid_i) begin
          err_q  <= job_i.err;
          s_re_q <= job_i.s_re;
          s_im_q <= job_i.s_im;
          t_re_q <= job_i.t_re;
          t_im_q <= job_i.t_im;
        end
      end
      simp_pkg::F_SUM: begin
        n_re_q <= (NW'(s_re_q) <<< 3) + (NW'(t_re_q) <<< 3) + NW'(t_re_q);
        n_im_q <= (NW'(s_im_q) <<< 3) + (NW'(t_im_q) <<< 3) + NW'(t_im_q);
      end
      simp_pkg::F_MAG: begin
        neg_re_q <= n_re_q[NW-1];
        neg_im_q <= n_im_q[NW-1];
        mag_re_q <= n_re_q[NW-1] ? (~n_re_q + NW'(1)) : n_re_q;
        mag_im_q <= n_im_q[NW-1] ? (~n_im_q + NW'(1)) : n_im_q;
      end
      simp_pkg::F_MUL: begin
        pl_re_q <= simp_pkg::PL_W'(mag_re_q[LO-1:0]) * simp_pkg::PL_W'(step_h_i);
        pl_im_q <= simp_pkg::PL_W'(mag_im_q[LO-1:0]) * simp_pkg::PL_W'(step_h_i);
        ph_re_q <= simp_pkg::PH_W'(mag_re_q[NW-1:LO]) * simp_pkg::PH_W'(step_h_i);
        ph_im_q <= simp_pkg::PH_W'(mag_im_q[NW-1:LO]) * simp_pkg::PH_W'(step_h_i);
      end
      simp_pkg::F_ADD: begin
        div_re_q <= DW'(p_re[PRW-1:3]);
        div_im_q <= DW'(p_im[PRW-1:3]);
        quo_re_q <= '0;
        quo_im_q <= '0;
        rem_re_q <= '0;
        rem_im_q <= '0;
      end
      simp_pkg::F_DIV: begin
        div_re_q <= div_re_q << DG;
        div_im_q <= div_im_q << DG;
        quo_re_q <= {quo_re_q[DW-DG-1:0], dig_re[DG-1:0]};
        quo_im_q <= {quo_im_q[DW-DG-1:0], dig_im[DG-1:0]};
        rem_re_q <= dig_re[DG+1:DG];
        rem_im_q <= dig_im[DG+1:DG];
      end
      simp_pkg::F_OUT: begin
        if (write_out) begin
          out_err_q <= err_q;
          out_re_q  <= err_q ? '0 : sat_out(neg_re_q, quo_re_q);
          out_im_q  <= err_q ? '0 : sat_out(neg_im_q, quo_im_q);
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/simpson_integrator.sv @@
// An integral's result beat follows the beat carrying its last sample through the FIFO,
// the accumulator and the scaling sequencer; when fewer than 3 points are set, each sample
// beat gets an error beat that skips the scaling steps. Sample beats are taken one per cycle
// while the FIFO has room; the sequencer (4 setup steps, then a divide-by-3 of one byte per
// cycle) takes one integral at a time, so a short run can wait on it, as can error beats.
// Reset (rst_ni low, async): run state cleared, num_points = 3, step_h = 1.0.
module simpson_integrator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [simp_pkg::IN_DATA_W-1:0]        s_axis_tdata_i,  // sample_re, sample_im
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [simp_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,  // integral_re, integral_im
  output logic                                  m_axis_tuser_o,  // too_few_points
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [simp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [simp_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int SW = simp_pkg::SAMPLE_WIDTH;

  logic [simp_pkg::NUM_W-1:0]  num_points_q, num_points_d;
  logic [simp_pkg::STEP_W-1:0] step_h_q, step_h_d;

  logic             push, push_ready, head_valid, pop, fin_ready, job_valid;
  simp_pkg::entry_t push_entry, head;
  simp_pkg::job_t   job;
  logic [simp_pkg::OUT_W-1:0] out_re, out_im;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    num_points_d = num_points_q;
    step_h_d     = step_h_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        simp_pkg::REG_NUM_POINTS: num_points_d = cfg_data_i[simp_pkg::NUM_W-1:0];
        simp_pkg::REG_STEP_H:     step_h_d     = cfg_data_i[simp_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= simp_pkg::NUM_POINTS_RST;
      step_h_q     <= simp_pkg::STEP_H_RST;
    end else begin
      num_points_q <= num_points_d;
      step_h_q     <= step_h_d;
    end
  end

  simp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_re_i      (s_axis_tdata_i[SW-1:0]),
    .in_im_i      (s_axis_tdata_i[2*SW-1:SW]),
    .num_points_i (num_points_q),
    .push_o       (push),
    .push_ready_i (push_ready),
    .entry_o      (push_entry)
  );

  simp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_entry),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_o       (head)
  );

  simp_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .fin_ready_i  (fin_ready),
    .job_valid_o  (job_valid),
    .job_o        (job)
  );

  simp_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .ready_o     (fin_ready),
    .step_h_i    (step_h_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_re_o    (out_re),
    .out_im_o    (out_im),
    .out_err_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {out_im, out_re};

endmodule

@@ src/simp_checker.sv @@
module simp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_i,
  input logic                              m_axis_tready_i,
  input logic [simp_pkg::OUT_DATA_W-1:0]   m_axis_tdata_i,
  input logic                              m_axis_tuser_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i))
    else $error("output beat changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tuser_i |-> m_axis_tdata_i == '0)
    else $error("error beat carries a nonzero integral");

  a_rst_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_i)
    else $error("output valid during reset");

endmodule

bind simpson_integrator simp_checker u_simp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import simp_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    too_few;
  } integral_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    s_valid   = 1'b0;
  logic                    s_ready;
  logic [IN_DATA_W-1:0]    s_data    = '0;
  logic                    m_valid;
  logic                    m_ready   = 1'b0;
  logic [OUT_DATA_W-1:0]   m_data;
  logic                    m_user;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int failures       = 0;

  integral_t expected_integrals[$];

  logic [NUM_W-1:0]       num_points_q;
  logic [STEP_W-1:0]      step_h_q;
  logic [COUNT_WIDTH-1:0] point_idx;
  longint                 simp_re, simp_im, tail_re, tail_im;

  simpson_integrator u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk) begin
    m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Integral predictor

  function automatic void clear_run();
    point_idx = '0;
    simp_re   = 0;
    simp_im   = 0;
    tail_re   = 0;
    tail_im   = 0;
  endfunction

  function automatic longint sat_accum(longint acc, longint delta, int w);
    longint lim, r;
    lim = longint'(1) <<< (w - 1);
    r   = acc + delta;
    if (r > lim - 1) return lim - 1;
    if (r < -lim) return -lim;
    return r;
  endfunction

  // (8*S + 9*T) * h / 24, rounded half away from zero, saturated
  function automatic logic [OUT_W-1:0] scale_integral(longint s, longint t,
                                                      logic [STEP_W-1:0] h);
    longint       n;
    logic         neg;
    logic [127:0] mag, q;
    n   = 8 * s + 9 * t;
    neg = (n < 0);
    mag = neg ? 128'(-n) : 128'(n);
    q   = (mag * 128'(h) + 128'd12) / 128'd24;
    if (q >= (128'd1 << 63)) return neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return neg ? -q[63:0] : q[63:0];
  endfunction

  function automatic int simpson_tap(int i, int last);
    if (i == 0 || i == last) return 1;
    return (i % 2) ? 4 : 2;
  endfunction

  function automatic void integrate_sample(logic signed [SAMPLE_WIDTH-1:0] re,
                                           logic signed [SAMPLE_WIDTH-1:0] im);
    int        n, i, ws, wt;
    integral_t res;
    n  = int'(num_points_q[COUNT_WIDTH-1:0]);
    ws = 0;
    wt = 0;
    if (n < 3) begin
      clear_run();
      res.re      = '0;
      res.im      = '0;
      res.too_few = 1'b1;
      expected_integrals.push_back(res);
      return;
    end
    if (int'(point_idx) >= n) clear_run();
    i = int'(point_idx);
    if (n % 2) begin
      ws = simpson_tap(i, n - 1);
    end else begin
      if (n > 4 && i <= n - 4) ws = simpson_tap(i, n - 4);
      if (i >= n - 4) wt = (i == n - 4 || i == n - 1) ? 1 : 3;
    end
    simp_re = sat_accum(simp_re, longint'(re) * ws, SUM_S_W);
    simp_im = sat_accum(simp_im, longint'(im) * ws, SUM_S_W);
    tail_re = sat_accum(tail_re, longint'(re) * wt, SUM_T_W);
    tail_im = sat_accum(tail_im, longint'(im) * wt, SUM_T_W);
    if (i + 1 < n) begin
      point_idx = COUNT_WIDTH'(i + 1);
      return;
    end
    res.re      = scale_integral(simp_re, tail_re, step_h_q);
    res.im      = scale_integral(simp_im, tail_im, step_h_q);
    res.too_few = 1'b0;
    expected_integrals.push_back(res);
    clear_run();
  endfunction

  always @(posedge clk) begin : check_integrals
    integral_t want;
    if (m_valid && m_ready) begin
      if (expected_integrals.size() == 0) begin
        failures++;
        $display("%0t: unexpected beat: expected none, actual re=%h im=%h too_few=%b",
                 $time, m_data[OUT_W-1:0], m_data[OUT_DATA_W-1:OUT_W], m_user);
      end else begin
        want = expected_integrals.pop_front();
        if (m_data[OUT_W-1:0] !== want.re) begin
          failures++;
          $display("%0t: integral_re expected %h actual %h",
                   $time, want.re, m_data[OUT_W-1:0]);
        end
        if (m_data[OUT_DATA_W-1:OUT_W] !== want.im) begin
          failures++;
          $display("%0t: integral_im expected %h actual %h",
                   $time, want.im, m_data[OUT_DATA_W-1:OUT_W]);
        end
        if (m_user !== want.too_few) begin
          failures++;
          $display("%0t: too_few_points expected %b actual %b",
                   $time, want.too_few, m_user);
        end
      end
    end
  end

  // Stimulus

  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] re,
                             input logic [SAMPLE_WIDTH-1:0] im);
    int gap;
    gap = 0;
    while (gap < 50 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {im, re};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    integrate_sample(re, im);
  endtask

  // drop valid, wait for all results, then let in-flight samples retire
  task automatic settle();
    @(negedge clk);
    s_valid <= 1'b0;
    while (expected_integrals.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_NUM_POINTS) num_points_q = value[NUM_W-1:0];
    else if (idx == REG_STEP_H) step_h_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int n, input logic [STEP_W-1:0] h);
    settle();
    write_reg(REG_NUM_POINTS, CFG_DATA_W'(n));
    write_reg(REG_STEP_H, h);
  endtask

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      2:       return '0;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_too_few_points();
    configure(0, '0);
    send_sample(pick_sample(), pick_sample());
    configure(1, 32'h0100_0000);
    send_sample(pick_sample(), pick_sample());
    configure(2, 32'h0100_0000);
    send_sample(pick_sample(), pick_sample());
    send_sample(pick_sample(), pick_sample());
  endtask

  task automatic test_three_eighths_only();
    configure(4, 32'h0180_0000);
    repeat (4) send_sample(pick_sample(), pick_sample());
  endtask

  task automatic test_simpson_with_tail();
    configure(6, 32'h0040_0000);
    repeat (6) send_sample(pick_sample(), pick_sample());
  endtask

  task automatic test_output_saturation();
    configure(3, '1);
    repeat (3) send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
  endtask

  // shrink the count below the current position mid-integral
  task automatic test_count_change();
    configure(7, '1);
    repeat (4) send_sample(pick_sample(), pick_sample());
    settle();
    write_reg(REG_NUM_POINTS, CFG_DATA_W'(3));
    repeat (3) send_sample(32'h8000_0000, 32'h8000_0000);
  endtask

  task automatic test_longest_run();
    configure(65535, $urandom_range(32'h0010_0000));
    repeat (64) send_sample(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
  endtask

  task automatic test_random_integrals(input int send_pct, input int stall_pct,
                                       input int items);
    int                sent, n, len;
    logic [STEP_W-1:0] h;
    sent = 0;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    while (sent < items) begin
      case ($urandom_range(9))
        0:       n = $urandom_range(2);
        1:       n = $urandom_range(40, 13);
        default: n = $urandom_range(12, 3);
      endcase
      case ($urandom_range(7))
        0:       h = '0;
        1:       h = '1;
        2, 3:    h = STEP_W'($urandom);
        default: h = STEP_W'($urandom_range(32'h0400_0000));
      endcase
      configure(n, h);
      repeat ($urandom_range(4, 1)) begin
        if (n < 3) len = $urandom_range(3, 1);
        else if ($urandom_range(7) == 0) len = $urandom_range(n - 1, 1);
        else len = n;
        repeat (len) send_sample(pick_sample(), pick_sample());
        sent += len;
      end
    end
  endtask

  initial begin
    clear_run();
    num_points_q = NUM_POINTS_RST;
    step_h_q     = STEP_H_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_too_few_points();
    test_three_eighths_only();
    test_simpson_with_tail();
    test_output_saturation();
    test_count_change();
    test_longest_run();
    test_random_integrals(0, 0, 190);
    test_random_integrals(80, 0, 190);
    test_random_integrals(0, 80, 190);
    test_random_integrals(23, 23, 190);
    settle();

    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
